/* rtl/att_pkg.sv */
// Shared widths, codes and register indexes of the animation timeline timer.
package att_pkg;

    localparam int NUM_EVENTS = 4;
    localparam int TIME_W     = 16;
    localparam int PROG_W     = 17;
    localparam int CMD_W      = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int CNT_W      = 5;

    // Divider pass lengths: progress needs sixteen fraction bits, the wrap
    // modulo a seventeen-bit dividend.
    localparam logic [CNT_W-1:0] PROG_STEPS = CNT_W'(16);
    localparam logic [CNT_W-1:0] MOD_STEPS  = CNT_W'(17);

    localparam logic [PROG_W-1:0] ONE_Q16      = 17'h10000;
    localparam logic [TIME_W-1:0] DURATION_RST = 16'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_ADVANCE = 2'd2
    } cmd_t;

    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_AT0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_AT1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_AT2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_AT3 = 3'd6;

endpackage

/* rtl/att_cmd_if.sv */
// Command channel of the timeline timer: valid/ready with cmd and dt.
interface att_cmd_if;
    import att_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [TIME_W-1:0]   dt;

    modport source (output valid, output cmd, output dt, input ready);
    modport sink   (input valid, input cmd, input dt, output ready);
endinterface

/* rtl/att_status_if.sv */
// Status channel of the timeline timer: valid/ready with one step result.
interface att_status_if;
    import att_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TIME_W-1:0]      time_now;
    logic [PROG_W-1:0]      progress;
    logic                   playing;
    logic                   reversing;
    logic [NUM_EVENTS-1:0]  events_fired;
    logic                   completed;

    modport source (output valid, output time_now, output progress, output playing,
                    output reversing, output events_fired, output completed,
                    input ready);
    modport sink   (input valid, input time_now, input progress, input playing,
                    input reversing, input events_fired, input completed,
                    output ready);
endinterface

/* rtl/animation_timeline_timer_top.sv */
// Top level of the timeline timer: sequencer around one shared restoring divider.
//
//  channel     | dir | request                   | handshake
//  ------------+-----+---------------------------+------------------
//  cmd_ch      | in  | cmd, dt                   | valid / ready
//  status_ch   | out | time_now .. completed     | valid / ready
//  cfg         | in  | cfg_index, cfg_data       | cfg_we, no stall
//
//  Start, stop and advance-while-stopped run at most one divide; an advance
//  that moves the timeline runs up to three, then waits on status_ch.ready.
//  The one shared divider resolves one bit per cycle: 16 steps per progress
//  value (one before and one after the wrap) and 17 steps per loop wrap.
//  cmd_ch.ready is high only in idle; a result holds until taken.
//  Reset clears the timeline state and loads the register defaults.
module animation_timeline_timer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [att_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [att_pkg::CFG_DATA_W-1:0]  cfg_data,
    att_cmd_if.sink                         cmd_ch,
    att_status_if.source                    status_ch
);
    import att_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PRE  = 8'b0000_0010,
        S_DIV1 = 8'b0000_0100,
        S_EVT  = 8'b0000_1000,
        S_MOD  = 8'b0001_0000,
        S_PRE2 = 8'b0010_0000,
        S_DIV2 = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [TIME_W-1:0]      dur_reg, dur_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [NUM_EVENTS-1:0]  en_reg, en_next;
    logic [PROG_W-1:0]      at_reg [NUM_EVENTS];
    logic [PROG_W-1:0]      at_next [NUM_EVENTS];

    // timeline state
    logic [TIME_W-1:0]      pos_reg, pos_next;
    logic                   running_reg, running_next;
    logic                   backward_reg, backward_next;
    logic [NUM_EVENTS-1:0]  marks_reg, marks_next;

    // per-step working values
    logic signed [TIME_W+1:0] t_reg, t_next;
    logic [PROG_W-1:0]      p_reg, p_next;
    logic [PROG_W-1:0]      prog_reg, prog_next;
    logic [NUM_EVENTS-1:0]  fired_reg, fired_next;
    logic                   done_reg, done_next;
    logic                   wrap_lo_reg, wrap_lo_next;

    // shared divider
    logic [TIME_W-1:0]      rem_reg, rem_next;
    logic [TIME_W:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [TIME_W-1:0]      eff_d;
    logic signed [TIME_W+1:0] d_s;
    logic signed [TIME_W+1:0] t_adv, t_m1, t_neg;
    logic [TIME_W:0]        rem_sh, rem_sub;
    logic                   ge;
    logic [TIME_W-1:0]      rem_step;
    logic                   t_le0, t_ge_d, t_gt_d;
    logic [NUM_EVENTS-1:0]  hit;

    assign eff_d = (dur_reg == '0) ? TIME_W'(1) : dur_reg;
    assign d_s   = $signed({2'b00, eff_d});

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh   = {rem_reg, quo_reg[TIME_W]};
    assign rem_sub  = rem_sh - {1'b0, eff_d};
    assign ge       = (rem_sh >= {1'b0, eff_d});
    assign rem_step = ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];

    assign t_adv = backward_reg ? ($signed({2'b00, pos_reg}) - $signed({2'b00, cmd_ch.dt}))
                                : ($signed({2'b00, pos_reg}) + $signed({2'b00, cmd_ch.dt}));
    assign t_m1  = t_reg - 18'sd1;
    assign t_neg = -t_reg;
    assign t_le0  = t_reg[TIME_W+1] || (t_reg == '0);
    assign t_ge_d = (t_reg >= d_s);
    assign t_gt_d = (t_reg > d_s);

    always_comb
    begin
        for (int i = 0; i < NUM_EVENTS; i++)
        begin
            hit[i] = en_reg[i] && !marks_reg[i] && (p_reg >= at_reg[i]);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        dur_next      = dur_reg;
        mode_next     = mode_reg;
        en_next       = en_reg;
        at_next       = at_reg;
        pos_next      = pos_reg;
        running_next  = running_reg;
        backward_next = backward_reg;
        marks_next    = marks_reg;
        t_next        = t_reg;
        p_next        = p_reg;
        prog_next     = prog_reg;
        fired_next    = fired_reg;
        done_next     = done_reg;
        wrap_lo_next  = wrap_lo_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_DURATION:  dur_next   = cfg_data[TIME_W-1:0];
                REG_PLAY_MODE: mode_next  = cfg_data[MODE_W-1:0];
                REG_EVENT_EN:  en_next    = cfg_data[NUM_EVENTS-1:0];
                REG_EVENT_AT0: at_next[0] = cfg_data[PROG_W-1:0];
                REG_EVENT_AT1: at_next[1] = cfg_data[PROG_W-1:0];
                REG_EVENT_AT2: at_next[2] = cfg_data[PROG_W-1:0];
                REG_EVENT_AT3: at_next[3] = cfg_data[PROG_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    fired_next = '0;
                    done_next  = 1'b0;
                    state_next = S_PRE2;
                    case (cmd_ch.cmd)
                        CMD_START:
                        begin
                            pos_next      = '0;
                            running_next  = 1'b1;
                            backward_next = 1'b0;
                            marks_next    = '0;
                        end
                        CMD_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        CMD_ADVANCE:
                        begin
                            if (running_reg)
                            begin
                                t_next     = t_adv;
                                state_next = S_PRE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_PRE:
            begin
                if (t_le0)
                begin
                    p_next     = '0;
                    state_next = S_EVT;
                end
                else if (t_ge_d)
                begin
                    p_next     = ONE_Q16;
                    state_next = S_EVT;
                end
                else
                begin
                    rem_next   = t_reg[TIME_W-1:0];
                    quo_next   = '0;
                    cnt_next   = PROG_STEPS;
                    state_next = S_DIV1;
                end
            end

            S_DIV1:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = rem_step;
                    quo_next = {quo_reg[TIME_W-1:0], ge};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    p_next     = {1'b0, quo_reg[TIME_W-1:0]};
                    state_next = S_EVT;
                end
            end

            S_EVT:
            begin
                // fire events on the unwrapped time, then wrap, clamp or reflect
                marks_next = marks_reg | hit;
                fired_next = hit;
                state_next = S_PRE2;
                if (mode_reg == MODE_LOOP)
                begin
                    if (t_gt_d)
                    begin
                        wrap_lo_next = 1'b0;
                        done_next    = !backward_reg;
                        rem_next     = '0;
                        quo_next     = t_m1[TIME_W:0];
                        cnt_next     = MOD_STEPS;
                        state_next   = S_MOD;
                    end
                    else if (t_reg[TIME_W+1])
                    begin
                        wrap_lo_next = 1'b1;
                        done_next    = backward_reg;
                        rem_next     = '0;
                        quo_next     = {1'b0, t_neg[TIME_W-1:0]};
                        cnt_next     = MOD_STEPS;
                        state_next   = S_MOD;
                    end
                    else
                    begin
                        pos_next = t_reg[TIME_W-1:0];
                    end
                end
                else if (mode_reg == MODE_PINGPONG)
                begin
                    if (t_gt_d)
                    begin
                        pos_next      = eff_d;
                        backward_next = 1'b1;
                    end
                    else if (t_reg[TIME_W+1])
                    begin
                        pos_next      = '0;
                        backward_next = 1'b0;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        pos_next = t_reg[TIME_W-1:0];
                    end
                end
                else
                begin
                    if (t_ge_d)
                    begin
                        pos_next     = eff_d;
                        running_next = 1'b0;
                        done_next    = 1'b1;
                    end
                    else if (t_reg[TIME_W+1])
                    begin
                        pos_next     = '0;
                        running_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = t_reg[TIME_W-1:0];
                    end
                end
            end

            S_MOD:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = rem_step;
                    quo_next = {quo_reg[TIME_W-1:0], ge};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    // upper wrap lands in 1..d, lower wrap in 0..d-1
                    if (wrap_lo_reg)
                    begin
                        pos_next = (rem_reg == '0) ? '0 : (eff_d - rem_reg);
                    end
                    else
                    begin
                        pos_next = rem_reg + TIME_W'(1);
                    end
                    state_next = S_PRE2;
                end
            end

            S_PRE2:
            begin
                if (pos_reg == '0)
                begin
                    prog_next  = '0;
                    state_next = S_OUT;
                end
                else if (pos_reg >= eff_d)
                begin
                    prog_next  = ONE_Q16;
                    state_next = S_OUT;
                end
                else
                begin
                    rem_next   = pos_reg;
                    quo_next   = '0;
                    cnt_next   = PROG_STEPS;
                    state_next = S_DIV2;
                end
            end

            S_DIV2:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = rem_step;
                    quo_next = {quo_reg[TIME_W-1:0], ge};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    prog_next  = {1'b0, quo_reg[TIME_W-1:0]};
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (status_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dur_reg      <= DURATION_RST;
            mode_reg     <= MODE_ONCE;
            en_reg       <= '0;
            for (int i = 0; i < NUM_EVENTS; i++)
            begin
                at_reg[i] <= '0;
            end
            pos_reg      <= '0;
            running_reg  <= 1'b0;
            backward_reg <= 1'b0;
            marks_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            dur_reg      <= dur_next;
            mode_reg     <= mode_next;
            en_reg       <= en_next;
            at_reg       <= at_next;
            pos_reg      <= pos_next;
            running_reg  <= running_next;
            backward_reg <= backward_next;
            marks_reg    <= marks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        p_reg       <= p_next;
        prog_reg    <= prog_next;
        fired_reg   <= fired_next;
        done_reg    <= done_next;
        wrap_lo_reg <= wrap_lo_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
    end

    assign cmd_ch.ready           = (state_reg == S_IDLE);
    assign status_ch.valid        = (state_reg == S_OUT);
    assign status_ch.time_now     = pos_reg;
    assign status_ch.progress     = prog_reg;
    assign status_ch.playing      = running_reg;
    assign status_ch.reversing    = backward_reg;
    assign status_ch.events_fired = fired_reg;
    assign status_ch.completed    = done_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_ch.ready && status_ch.valid))
        else $error("command taken while a result is pending");

    a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
        status_ch.valid |-> (status_ch.progress <= ONE_Q16))
        else $error("progress above one");

    a_fired_marked: assert property (@(posedge clk) disable iff (!rst_n)
        status_ch.valid |-> ((status_ch.events_fired & ~marks_reg) == '0))
        else $error("event reported without its fired mark");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV1) |-> ((t_reg > 18'sd0) && (t_reg < d_s)))
        else $error("progress divide started outside the open range");

endmodule
